// File: rtl/core/sppq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sppq_pkg
// Types, sizes and operation codes shared by the priority queue modules.
// ----------------------------------------------------------------------------
package sppq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int PRIO_BITS   = 8;

	localparam int ID_W   = 4;
	localparam int IN_PRIO_W = 8;
	localparam int IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

	localparam logic [1:0] FUNC_INSERT    = 2'd0;
	localparam logic [1:0] FUNC_POP_HEAD  = 2'd1;
	localparam logic [1:0] FUNC_PEEK_HEAD = 2'd2;
	localparam logic [1:0] FUNC_REMOVE_ID = 2'd3;

	typedef logic [ID_W-1:0]      id_t;
	typedef logic [PRIO_BITS-1:0] prio_t;
	typedef logic [IDX_W-1:0]     idx_t;
	typedef logic [CNT_W-1:0]     cnt_t;

	typedef struct packed {
		id_t   id;
		prio_t prio;
	} slot_t;

	typedef struct packed {
		logic  en;
		idx_t  addr;
		slot_t data;
	} slot_wr_t;

	typedef struct packed {
		logic [1:0] func;
		id_t        id;
		prio_t      prio;
	} cmd_t;

	typedef struct packed {
		logic hit;
		id_t  out_id;
		logic queue_empty;
		logic overflow;
	} res_t;

	// low PRIO_BITS bits of the input priority, zero extended when wider
	function automatic prio_t prio_of(input logic [IN_PRIO_W-1:0] p);
		logic [PRIO_BITS+IN_PRIO_W-1:0] w;
		w = {{PRIO_BITS{1'b0}}, p};
		return w[PRIO_BITS-1:0];
	endfunction

endpackage

// File: rtl/core/stable_priority_process_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_priority_process_queue
// Ready queue of process ids in descending priority, equal priorities FIFO.
// Insert walks the slot store backward from the tail to the insert point;
// pop and remove-by-id walk forward over every occupied slot; peek reads
// only the head, and skips the read when the queue is empty.
// One item at a time: s_tready is high only while the sequencer is idle.
// Reset empties the queue at once; the slot store itself is not cleared.
// ----------------------------------------------------------------------------
module stable_priority_process_queue (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // proc_id[3:0], prio[11:4], zero pad
	input  logic [1:0]  s_tuser,  // func[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata   // hit[0], out_id[4:1], queue_empty[5], overflow[6], pad
);
	import sppq_pkg::*;

	cmd_t     cmd;
	res_t     res;
	logic     res_valid;
	logic     res_ready;
	slot_wr_t wr;
	idx_t     raddr;
	slot_t    rdata;

	logic     m_tvalid_q;
	res_t     m_res_q;

	assign cmd.func = s_tuser;
	assign cmd.id   = s_tdata[ID_W-1:0];
	assign cmd.prio = prio_of(s_tdata[ID_W+IN_PRIO_W-1:ID_W]);

	// output register frees as soon as the downstream beat is taken
	assign res_ready = !m_tvalid_q || m_tready;

	sppq_walker u_walker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (s_tvalid),
		.cmd_ready (s_tready),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.wr        (wr),
		.raddr     (raddr),
		.rdata     (rdata)
	);

	sppq_slot_ram u_slot_ram (
		.clk   (clk),
		.wr    (wr),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			m_res_q <= '{hit: res.hit, out_id: res.out_id,
				queue_empty: res.queue_empty, overflow: res.overflow};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, m_res_q.overflow, m_res_q.queue_empty,
		m_res_q.out_id, m_res_q.hit};

endmodule

// File: rtl/core/sppq_slot_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sppq_slot_ram
// Slot store of the queue: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module sppq_slot_ram (
	input  logic              clk,
	input  sppq_pkg::slot_wr_t wr,
	input  sppq_pkg::idx_t    raddr,
	output sppq_pkg::slot_t   rdata
);
	import sppq_pkg::*;

	slot_t mem_q [QUEUE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/core/sppq_walker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sppq_walker
// Sequencer that walks the slot store one slot a cycle through a single
// priority compare and id match unit, shifting entries as it goes.
// ----------------------------------------------------------------------------
module sppq_walker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  sppq_pkg::cmd_t    cmd,
	output logic              res_valid,
	input  logic              res_ready,
	output sppq_pkg::res_t    res,
	output sppq_pkg::slot_wr_t wr,
	output sppq_pkg::idx_t    raddr,
	input  sppq_pkg::slot_t   rdata
);
	import sppq_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_INS  = 3'd1;
	localparam logic [2:0] ST_PUT0 = 3'd2;
	localparam logic [2:0] ST_FWD  = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	logic [2:0] state_q, state_d;
	cnt_t       cnt_q, cnt_d;
	idx_t       k_q, k_d;
	logic       found_q, found_d;
	cmd_t       cmd_q, cmd_d;
	res_t       res_q, res_d;

	cnt_t cnt_m1;
	idx_t last_idx;
	logic higher;
	logic match;
	logic is_last;

	assign cnt_m1   = cnt_q - CNT_W'(1);
	assign last_idx = cnt_m1[IDX_W-1:0];
	// shared compare unit
	assign higher   = cmd_q.prio > rdata.prio;
	assign match    = (cmd_q.func == FUNC_POP_HEAD) ? (k_q == '0) : (rdata.id == cmd_q.id);
	assign is_last  = (k_q == last_idx);

	assign cmd_ready = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_FIN);
	// the count is already final once the sequencer sits in ST_FIN
	assign res       = '{hit: res_q.hit, out_id: res_q.out_id,
		queue_empty: (cnt_q == '0), overflow: res_q.overflow};

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		k_d     = k_q;
		found_d = found_q;
		cmd_d   = cmd_q;
		res_d   = res_q;
		raddr   = k_q;
		wr      = '0;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					cmd_d   = cmd;
					res_d   = '0;
					found_d = 1'b0;
					if (cmd.func == FUNC_INSERT) begin
						if (cnt_q == CNT_W'(QUEUE_DEPTH)) begin
							res_d.overflow = 1'b1;
							state_d = ST_FIN;
						end else if (cnt_q == '0) begin
							wr.en   = 1'b1;
							wr.addr = '0;
							wr.data = '{id: cmd.id, prio: cmd.prio};
							cnt_d   = cnt_q + CNT_W'(1);
							res_d.hit = 1'b1;
							state_d = ST_FIN;
						end else begin
							raddr   = last_idx;
							k_d     = last_idx;
							state_d = ST_INS;
						end
					end else if (cnt_q == '0) begin
						state_d = ST_FIN;
					end else begin
						raddr   = '0;
						k_d     = '0;
						state_d = ST_FWD;
					end
				end
			end
			ST_INS: begin
				// walk from the back, moving lower priorities up one slot
				wr.en   = 1'b1;
				wr.addr = k_q + IDX_W'(1);
				if (higher) begin
					wr.data = rdata;
					if (k_q == '0) begin
						state_d = ST_PUT0;
					end else begin
						raddr = k_q - IDX_W'(1);
						k_d   = k_q - IDX_W'(1);
					end
				end else begin
					wr.data   = '{id: cmd_q.id, prio: cmd_q.prio};
					cnt_d     = cnt_q + CNT_W'(1);
					res_d.hit = 1'b1;
					state_d   = ST_FIN;
				end
			end
			ST_PUT0: begin
				wr.en     = 1'b1;
				wr.addr   = '0;
				wr.data   = '{id: cmd_q.id, prio: cmd_q.prio};
				cnt_d     = cnt_q + CNT_W'(1);
				res_d.hit = 1'b1;
				state_d   = ST_FIN;
			end
			ST_FWD: begin
				if (cmd_q.func == FUNC_PEEK_HEAD) begin
					res_d.hit    = 1'b1;
					res_d.out_id = rdata.id;
					state_d      = ST_FIN;
				end else begin
					// once the entry is found, every later one moves down a slot
					if (found_q) begin
						wr.en   = 1'b1;
						wr.addr = k_q - IDX_W'(1);
						wr.data = rdata;
					end else if (match) begin
						found_d      = 1'b1;
						res_d.hit    = 1'b1;
						res_d.out_id = rdata.id;
					end
					if (is_last) begin
						if (found_q || match) begin
							cnt_d = cnt_m1;
						end
						state_d = ST_FIN;
					end else begin
						raddr = k_q + IDX_W'(1);
						k_d   = k_q + IDX_W'(1);
					end
				end
			end
			ST_FIN: begin
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		k_q     <= k_d;
		found_q <= found_d;
		cmd_q   <= cmd_d;
		res_q   <= res_d;
	end

endmodule
